>>> hdl/diq_pkg.sv
// Shared types, constants and register indexes for the digital input qualifier.
package diq_pkg;

   // Field and register widths
   localparam int ANALOG_W       = 32;
   localparam int LIMIT_W        = 32;
   localparam int BAND_W         = 31;
   localparam int DELAY_W        = 16;
   localparam int WIDE_W         = 33;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 32;
   localparam int TIMER_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   // Operation codes on the request channel
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_INVERT_ENABLE    = 3'd0,
      REG_JAR_DELAY        = 3'd1,
      REG_RISE_DELAY       = 3'd2,
      REG_FALL_DELAY       = 3'd3,
      REG_THRESHOLD_ENABLE = 3'd4,
      REG_LOW_LIMIT        = 3'd5,
      REG_HIGH_LIMIT       = 3'd6,
      REG_HYSTERESIS_BAND  = 3'd7
   } reg_index_type;

   // Level class found by the front end
   typedef enum logic [1:0] {
      LEVEL_LOW  = 2'd0,
      LEVEL_HIGH = 2'd1,
      LEVEL_KEEP = 2'd2
   } level_type;

   typedef struct packed {
      logic                      invert_enable;
      logic [DELAY_W-1:0]        jar_delay;
      logic [DELAY_W-1:0]        rise_delay;
      logic [DELAY_W-1:0]        fall_delay;
      logic                      threshold_enable;
      logic signed [LIMIT_W-1:0] low_limit;
      logic signed [LIMIT_W-1:0] high_limit;
      logic [BAND_W-1:0]         hysteresis_band;
   } cfg_type;

   typedef struct packed {
      logic      is_tick;
      level_type level;
      logic      force_publish;
   } entry_type;

endpackage

>>> hdl/digital_input_qualifier_top.sv
// Top level of the digital input qualifier: register file and the front/queue/back chain.
//
// Request channel (req_*): one transfer per item. req_operation selects a sample
// or a one millisecond tick. A tick advances the timers and gives no response;
// a sample gives exactly one response transfer (rsp_qualified_bit, rsp_publish).
// Configuration is written through csr_write_enable/csr_index/csr_write_data,
// one register per cycle, with no handshake and no read-back.
// A sample accepted on the request channel is registered in the queue and then in
// the response register before it shows on rsp_valid. Throughput: one item per
// cycle while rsp_ready stays high, set by the filter update in the back end.
// A two-entry queue between the classifying front end and the back end, plus
// the response register, lets a tick keep moving while a response waits; when
// the receiver holds rsp_ready low, samples back up into the queue and
// req_ready falls once it is full.
// Reset clears the configuration, every timer and filter state, the queue and rsp_valid,
// but not the response payload; the block takes items in the first cycle after reset.
module digital_input_qualifier_top #(
   parameter int TIMER_BITS = diq_pkg::TIMER_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic                                  req_digital_in,
   input  logic signed [diq_pkg::ANALOG_W-1:0]   req_analog_in,
   input  logic                                  req_force_publish,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_qualified_bit,
   output logic                                  rsp_publish,
   input  logic                                  csr_write_enable,
   input  logic [diq_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [diq_pkg::CSR_DATA_W-1:0]        csr_write_data
);
   import diq_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // Register file write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_INVERT_ENABLE: begin
               cfg_in.invert_enable = csr_write_data[0];
            end
            REG_JAR_DELAY: begin
               cfg_in.jar_delay = csr_write_data[DELAY_W-1:0];
            end
            REG_RISE_DELAY: begin
               cfg_in.rise_delay = csr_write_data[DELAY_W-1:0];
            end
            REG_FALL_DELAY: begin
               cfg_in.fall_delay = csr_write_data[DELAY_W-1:0];
            end
            REG_THRESHOLD_ENABLE: begin
               cfg_in.threshold_enable = csr_write_data[0];
            end
            REG_LOW_LIMIT: begin
               cfg_in.low_limit = $signed(csr_write_data[LIMIT_W-1:0]);
            end
            REG_HIGH_LIMIT: begin
               cfg_in.high_limit = $signed(csr_write_data[LIMIT_W-1:0]);
            end
            REG_HYSTERESIS_BAND: begin
               cfg_in.hysteresis_band = csr_write_data[BAND_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   diq_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_digital_in    (req_digital_in),
      .req_analog_in     (req_analog_in),
      .req_force_publish (req_force_publish),
      .cfg               (cfg_ff),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   diq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   diq_back #(
      .TIMER_BITS (TIMER_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_qualified_bit (rsp_qualified_bit),
      .rsp_publish       (rsp_publish)
   );

endmodule

>>> hdl/diq_front.sv
// Front end: accepts request transfers and classifies each into a queue entry.
module diq_front (
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic                                 req_digital_in,
   input  logic signed [diq_pkg::ANALOG_W-1:0]  req_analog_in,
   input  logic                                 req_force_publish,
   input  diq_pkg::cfg_type                     cfg,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output diq_pkg::entry_type                   push_entry
);
   import diq_pkg::*;

   logic signed [WIDE_W-1:0] analog_wide;
   logic signed [WIDE_W-1:0] low_wide;
   logic signed [WIDE_W-1:0] high_wide;
   logic                     at_or_below;
   logic                     at_or_above;

   // Widen limits and band so the sums cannot overflow
   always_comb begin
      analog_wide = WIDE_W'(req_analog_in);
      low_wide    = WIDE_W'(cfg.low_limit) - $signed({2'b00, cfg.hysteresis_band});
      high_wide   = WIDE_W'(cfg.high_limit) + $signed({2'b00, cfg.hysteresis_band});
      at_or_below = (analog_wide <= low_wide);
      at_or_above = (analog_wide >= high_wide);
   end

   // Classify the level; the low test takes priority
   always_comb begin
      push_entry.is_tick       = (req_operation == OP_TICK);
      push_entry.force_publish = req_force_publish;
      if (cfg.threshold_enable) begin
         priority if (at_or_below) begin
            push_entry.level = LEVEL_LOW;
         end else if (at_or_above) begin
            push_entry.level = LEVEL_HIGH;
         end else begin
            push_entry.level = LEVEL_KEEP;
         end
      end else begin
         push_entry.level = req_digital_in ? LEVEL_HIGH : LEVEL_LOW;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

>>> hdl/diq_queue.sv
// Short queue between front end and back end.
module diq_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  diq_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output diq_pkg::entry_type pop_entry
);
   import diq_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      unique case ({do_push, do_pop})
         2'b10: begin
            count_in = CNT_W'(count_ff + 1'b1);
         end
         2'b01: begin
            count_in = CNT_W'(count_ff - 1'b1);
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry on a push
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hdl/diq_back.sv
// Back end: timers, bounce filter, on/off delays and the response register.
module diq_back #(
   parameter int TIMER_BITS = diq_pkg::TIMER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  diq_pkg::cfg_type   cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  diq_pkg::entry_type pop_entry,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_qualified_bit,
   output logic               rsp_publish
);
   import diq_pkg::*;

   localparam int CMP_W = (TIMER_BITS > DELAY_W) ? TIMER_BITS : DELAY_W;

   logic                  jar_last_input_ff, jar_last_input_in;
   logic                  jar_waiting_ff, jar_waiting_in;
   logic                  jar_output_ff, jar_output_in;
   logic [TIMER_BITS-1:0] jar_timer_ff, jar_timer_in;
   logic                  on_last_input_ff, on_last_input_in;
   logic [TIMER_BITS-1:0] on_timer_ff, on_timer_in;
   logic                  on_output_ff, on_output_in;
   logic                  off_last_input_ff, off_last_input_in;
   logic [TIMER_BITS-1:0] off_timer_ff, off_timer_in;
   logic                  off_output_ff, off_output_in;
   logic                  published_bit_ff, published_bit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_qualified_bit_ff, rsp_qualified_bit_in;
   logic                  rsp_publish_ff, rsp_publish_in;

   logic                  do_tick;
   logic                  do_sample;
   logic                  raw_bit;
   logic                  jar_bit;
   logic                  on_bit;
   logic                  off_bit;
   logic                  jar_wait_now;
   logic [TIMER_BITS-1:0] jar_timer_now;
   logic [TIMER_BITS-1:0] on_timer_now;
   logic [TIMER_BITS-1:0] off_timer_now;
   logic                  publish_now;

   // A tick never waits; a sample needs the response slot
   assign pop_ready = pop_entry.is_tick || !rsp_valid_ff || rsp_ready;
   assign do_tick   = pop_valid && pop_ready && pop_entry.is_tick;
   assign do_sample = pop_valid && pop_ready && !pop_entry.is_tick;

   function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
      sat_inc = (t == '1) ? t : TIMER_BITS'(t + 1'b1);
   endfunction

   function automatic logic timer_done(input logic [TIMER_BITS-1:0] t,
                                       input logic [DELAY_W-1:0] d);
      timer_done = (CMP_W'(t) >= CMP_W'(d));
   endfunction

   // Pick the raw level and apply inversion
   always_comb begin
      unique case (pop_entry.level)
         LEVEL_LOW: begin
            raw_bit = 1'b0;
         end
         LEVEL_HIGH: begin
            raw_bit = 1'b1;
         end
         default: begin
            raw_bit = published_bit_ff;
         end
      endcase
      raw_bit = raw_bit ^ cfg.invert_enable;
   end

   // Run the three filter stages and update state
   always_comb begin
      jar_last_input_in    = jar_last_input_ff;
      jar_waiting_in       = jar_waiting_ff;
      jar_output_in        = jar_output_ff;
      jar_timer_in         = jar_timer_ff;
      on_last_input_in     = on_last_input_ff;
      on_timer_in          = on_timer_ff;
      on_output_in         = on_output_ff;
      off_last_input_in    = off_last_input_ff;
      off_timer_in         = off_timer_ff;
      off_output_in        = off_output_ff;
      published_bit_in     = published_bit_ff;

      // Bounce filter: hold a change until the settle time has passed
      jar_wait_now  = jar_waiting_ff || (raw_bit != jar_last_input_ff);
      jar_timer_now = (!jar_waiting_ff && (raw_bit != jar_last_input_ff)) ? '0 : jar_timer_ff;
      if (cfg.jar_delay == '0) begin
         jar_bit = raw_bit;
      end else if (jar_wait_now && timer_done(jar_timer_now, cfg.jar_delay)) begin
         jar_bit = raw_bit;
      end else begin
         jar_bit = jar_output_ff;
      end

      // On-delay: confirm a rising edge after the delay
      on_timer_now = (jar_bit && !on_last_input_ff) ? '0 : on_timer_ff;
      if (cfg.rise_delay == '0) begin
         on_bit = jar_bit;
      end else if (!jar_bit || timer_done(on_timer_now, cfg.rise_delay)) begin
         on_bit = jar_bit;
      end else begin
         on_bit = on_output_ff;
      end

      // Off-delay: confirm a falling edge after the delay
      off_timer_now = (!on_bit && off_last_input_ff) ? '0 : off_timer_ff;
      if (cfg.fall_delay == '0) begin
         off_bit = on_bit;
      end else if (on_bit || timer_done(off_timer_now, cfg.fall_delay)) begin
         off_bit = on_bit;
      end else begin
         off_bit = off_output_ff;
      end

      publish_now = pop_entry.force_publish || (off_bit != published_bit_ff);

      if (do_tick) begin
         jar_timer_in = sat_inc(jar_timer_ff);
         on_timer_in  = sat_inc(on_timer_ff);
         off_timer_in = sat_inc(off_timer_ff);
      end else if (do_sample) begin
         jar_output_in = jar_bit;
         if (cfg.jar_delay != '0) begin
            jar_last_input_in = raw_bit;
            jar_timer_in      = jar_timer_now;
            jar_waiting_in    = jar_wait_now && !timer_done(jar_timer_now, cfg.jar_delay);
         end
         on_output_in = on_bit;
         if (cfg.rise_delay != '0) begin
            on_last_input_in = jar_bit;
            on_timer_in      = on_timer_now;
         end
         off_output_in = off_bit;
         if (cfg.fall_delay != '0) begin
            off_last_input_in = on_bit;
            off_timer_in      = off_timer_now;
         end
         if (publish_now) begin
            published_bit_in = off_bit;
         end
      end
   end

   // Load the response register on a sample, drop it once taken
   always_comb begin
      rsp_valid_in         = rsp_valid_ff;
      rsp_qualified_bit_in = rsp_qualified_bit_ff;
      rsp_publish_in       = rsp_publish_ff;
      if (do_sample) begin
         rsp_valid_in         = 1'b1;
         rsp_qualified_bit_in = off_bit;
         rsp_publish_in       = publish_now;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jar_last_input_ff <= 1'b0;
         jar_waiting_ff    <= 1'b0;
         jar_output_ff     <= 1'b0;
         jar_timer_ff      <= '0;
         on_last_input_ff  <= 1'b0;
         on_timer_ff       <= '0;
         on_output_ff      <= 1'b0;
         off_last_input_ff <= 1'b0;
         off_timer_ff      <= '0;
         off_output_ff     <= 1'b0;
         published_bit_ff  <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         jar_last_input_ff <= jar_last_input_in;
         jar_waiting_ff    <= jar_waiting_in;
         jar_output_ff     <= jar_output_in;
         jar_timer_ff      <= jar_timer_in;
         on_last_input_ff  <= on_last_input_in;
         on_timer_ff       <= on_timer_in;
         on_output_ff      <= on_output_in;
         off_last_input_ff <= off_last_input_in;
         off_timer_ff      <= off_timer_in;
         off_output_ff     <= off_output_in;
         published_bit_ff  <= published_bit_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_qualified_bit_ff <= rsp_qualified_bit_in;
      rsp_publish_ff       <= rsp_publish_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_qualified_bit = rsp_qualified_bit_ff;
   assign rsp_publish       = rsp_publish_ff;

endmodule
